// ===== rtl/base64_codec_defines.svh =====
// Assertion helpers shared by the codec modules.
// Both expect clk and arst_n in the enclosing module.
`ifndef BASE64_CODEC_DEFINES_SVH
`define BASE64_CODEC_DEFINES_SVH

// Same-cycle implication, held off during reset
`define B64C_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset
`define B64C_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/b64c_pkg.sv =====
`default_nettype none

package b64c_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [7:0] CHR_UPPER_A = 8'h41;
	localparam logic [7:0] CHR_LOWER_A = 8'h61;
	localparam logic [7:0] CHR_ZERO = 8'h30;
	localparam logic [7:0] CHR_PLUS = 8'h2B;
	localparam logic [7:0] CHR_SLASH = 8'h2F;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// One queued job: up to four result beats from a single input item
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [1:0]      cnt_m1;
		logic            msg_end;
		logic            no_data;
	} job_t;

	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] c;
		c = 8'h00;
		case (v) inside
			[6'd0:6'd25]:  c = CHR_UPPER_A + {2'b00, v};
			[6'd26:6'd51]: c = CHR_LOWER_A + {2'b00, v} - 8'd26;
			[6'd52:6'd61]: c = CHR_ZERO + {2'b00, v} - 8'd52;
			6'd62:         c = CHR_PLUS;
			default:       c = CHR_SLASH;
		endcase
		return c;
	endfunction

	// Bit 6 set marks a character outside the alphabet
	function automatic logic [6:0] dec_value(input logic [7:0] c);
		logic [6:0] v;
		v = 7'h40;
		case (c) inside
			[8'h41:8'h5A]: v = 7'(c - CHR_UPPER_A);
			[8'h61:8'h7A]: v = 7'(c - CHR_LOWER_A + 8'd26);
			[8'h30:8'h39]: v = 7'(c - CHR_ZERO + 8'd52);
			8'h2B:         v = 7'd62;
			8'h2F:         v = 7'd63;
			default:       v = 7'h40;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/b64c_front.sv =====
`default_nettype none

module b64c_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           mode_we,
	input  wire logic           mode_wdata,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [7:0]     in_byte,
	input  wire logic           last_of_message,
	input  wire logic           q_full,
	output logic                push,
	output b64c_pkg::job_t      job
);

`include "base64_codec_defines.svh"

	logic       mode_q;
	logic [7:0] buf_q [3];
	logic [1:0] cnt_q;
	logic       stop_q;

	logic [7:0] buf_n [3];
	logic [1:0] cnt_n;
	logic       stop_n;

	logic       acc;
	logic       emit;
	logic [7:0] g0, g1, g2;
	logic [5:0] v3;
	logic [2:0] nch;
	logic [6:0] dv;
	logic [1:0] c;
	logic       full_grp;
	logic [3:0][5:0] sx;

	assign in_stall = q_full;
	assign acc      = in_valid && !q_full;
	assign push     = acc && emit;

	always_comb begin
		buf_n    = buf_q;
		cnt_n    = cnt_q;
		stop_n   = stop_q;
		emit     = 1'b0;
		job      = '0;
		g0       = 8'h00;
		g1       = 8'h00;
		g2       = 8'h00;
		v3       = 6'h00;
		nch      = 3'd4;
		dv       = b64c_pkg::dec_value(in_byte);
		c        = cnt_q;
		full_grp = 1'b0;
		sx       = '0;

		if (mode_q == b64c_pkg::MODE_ENCODE) begin
			if (cnt_q == 2'd2) begin
				g0    = buf_q[0];
				g1    = buf_q[1];
				g2    = in_byte;
				emit  = 1'b1;
				cnt_n = 2'd0;
			end else begin
				for (int j = 0; j < 2; j++) begin
					if (2'(j) == cnt_q) buf_n[j] = in_byte;
				end
				cnt_n = cnt_q + 2'd1;
				if (last_of_message) begin
					// zero-fill the partial group
					g0   = (cnt_q == 2'd0) ? in_byte : buf_q[0];
					g1   = (cnt_q == 2'd0) ? 8'h00 : in_byte;
					emit = 1'b1;
					nch  = {1'b0, cnt_q} + 3'd2;
				end
			end
			sx[0] = g0[7:2];
			sx[1] = {g0[1:0], g1[7:4]};
			sx[2] = {g1[3:0], g2[7:6]};
			sx[3] = g2[5:0];
			for (int j = 0; j < 4; j++) begin
				job.data[j] = (3'(j) < nch) ? b64c_pkg::enc_char(sx[j]) : b64c_pkg::PAD_CHAR;
			end
			job.cnt_m1 = 2'd3;
		end else begin
			if (!stop_q) begin
				if (dv[6]) begin
					stop_n = 1'b1;
				end else if (cnt_q == 2'd3) begin
					full_grp = 1'b1;
					g0       = buf_q[0];
					g1       = buf_q[1];
					g2       = buf_q[2];
					v3       = dv[5:0];
					emit     = 1'b1;
					cnt_n    = 2'd0;
				end else begin
					for (int j = 0; j < 3; j++) begin
						if (2'(j) == cnt_q) buf_n[j] = {2'b00, dv[5:0]};
					end
					c     = cnt_q + 2'd1;
					cnt_n = c;
				end
			end
			if (!full_grp && last_of_message && c > 2'd1) begin
				// entries past the fill level read as zero
				g0   = buf_n[0];
				g1   = buf_n[1];
				g2   = (c == 2'd3) ? buf_n[2] : 8'h00;
				emit = 1'b1;
			end
			job.data[0] = {g0[5:0], g1[5:4]};
			job.data[1] = {g1[3:0], g2[5:2]};
			job.data[2] = {g2[1:0], v3};
			job.data[3] = 8'h00;
			job.cnt_m1  = full_grp ? 2'd2 : c - 2'd2;
		end

		if (last_of_message) begin
			job.msg_end = 1'b1;
			if (!emit) begin
				emit        = 1'b1;
				job.data    = '0;
				job.cnt_m1  = 2'd0;
				job.no_data = 1'b1;
			end
			buf_n  = '{default: 8'h00};
			cnt_n  = 2'd0;
			stop_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= b64c_pkg::MODE_ENCODE;
			buf_q  <= '{default: 8'h00};
			cnt_q  <= 2'd0;
			stop_q <= 1'b0;
		end else if (mode_we) begin
			// abandon any partial message
			mode_q <= mode_wdata;
			buf_q  <= '{default: 8'h00};
			cnt_q  <= 2'd0;
			stop_q <= 1'b0;
		end else if (acc) begin
			buf_q  <= buf_n;
			cnt_q  <= cnt_n;
			stop_q <= stop_n;
		end
	end

	`B64C_ASSERT_NOW(a_enc_cnt, mode_q == b64c_pkg::MODE_ENCODE, cnt_q != 2'd3, "encode group overfilled")
	`B64C_ASSERT_NOW(a_stop_dec, stop_q, mode_q == b64c_pkg::MODE_DECODE, "stop flag set while encoding")
	`B64C_ASSERT_NEXT(a_flush, acc && last_of_message, cnt_q == 2'd0 && !stop_q, "group not cleared at message end")

endmodule

`default_nettype wire

// ===== rtl/b64c_queue.sv =====
`default_nettype none

module b64c_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire b64c_pkg::job_t wr_job,
	output logic                full,
	input  wire logic           pop,
	output logic                rd_valid,
	output b64c_pkg::job_t      rd_job
);

	b64c_pkg::job_t                mem_q [b64c_pkg::QDEPTH];
	logic [b64c_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [b64c_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [b64c_pkg::QCNT_W-1:0]   cnt_q;

	assign full     = (cnt_q == b64c_pkg::QCNT_W'(b64c_pkg::QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == b64c_pkg::QPTR_W'(b64c_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == b64c_pkg::QPTR_W'(b64c_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/b64c_back.sv =====
`default_nettype none

module b64c_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           rd_valid,
	input  wire b64c_pkg::job_t rd_job,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          out_byte,
	output logic                run_last,
	output logic                message_end,
	output logic                no_data
);

`include "base64_codec_defines.svh"

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_last_q;
	logic       msg_end_q;
	logic       no_data_q;

	logic       load;
	logic       fin;

	assign load = rd_valid && (!valid_q || !out_stall);
	assign fin  = (idx_q == rd_job.cnt_m1);
	assign pop  = load && fin;

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign run_last    = run_last_q;
	assign message_end = msg_end_q;
	assign no_data     = no_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= fin ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// hold the beat while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q     <= rd_job.data[idx_q];
			run_last_q <= fin;
			msg_end_q  <= fin && rd_job.msg_end;
			no_data_q  <= rd_job.no_data;
		end
	end

	`B64C_ASSERT_NOW(a_idx, rd_valid, idx_q <= rd_job.cnt_m1, "beat index past end of job")
	`B64C_ASSERT_NOW(a_nodata, valid_q && no_data_q, byte_q == 8'h00 && run_last_q && msg_end_q, "end marker malformed")

endmodule

`default_nettype wire

// ===== rtl/base64_codec.sv =====
// Streaming base64 codec, standard alphabet with '=' padding.
// Config: mode_we/mode_wdata write the mode (0 encode, 1 decode); a write also
// drops any partial group. Write only while the codec is idle.
// Input channel: in_valid/in_stall carry in_byte and last_of_message; a beat is
// taken when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall carry out_byte, run_last, message_end and
// no_data, one result beat per cycle while out_stall is low.
// The front end gathers input beats into groups and queues a job of up to four
// results per group or message end into a two-entry queue; the back end plays
// jobs out one beat a cycle while out_stall is low. An item passes two
// registers: the queue entry, written when the item is taken, and the output
// register, which then loads from the queue head when it is free.
// Throughput: one input beat per cycle while the queue has room; the output
// side sets the pace, so encoding is bound by four output characters per three
// bytes and decoding runs at up to one character per cycle.
// Reset clears mode to encode, the group state, the queue, the output valid flag
// and the beat index. While out_stall is high the output beat holds; once the
// queue fills, in_stall rises.
`default_nettype none

module base64_codec (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       mode_we,
	input  wire logic       mode_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       last_of_message,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            message_end,
	output logic            no_data
);

	b64c_pkg::job_t wr_job;
	b64c_pkg::job_t rd_job;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           rd_valid;

	b64c_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.mode_we         (mode_we),
		.mode_wdata      (mode_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_byte         (in_byte),
		.last_of_message (last_of_message),
		.q_full          (q_full),
		.push            (push),
		.job             (wr_job)
	);

	b64c_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (wr_job),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (rd_valid),
		.rd_job   (rd_job)
	);

	b64c_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_valid    (rd_valid),
		.rd_job      (rd_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.message_end (message_end),
		.no_data     (no_data)
	);

endmodule

`default_nettype wire
